@@ hw/rtl/ccsf_pkg.sv @@
package ccsf_pkg;

  localparam int POINT_W  = 12;
  localparam int OUT_W    = 16;
  localparam int SIZE_W   = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SIZE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SIZE      = 2'd2;

  localparam logic [SIZE_W-1:0] MIN_SIZE_RESET = 13'd1;
  localparam logic [SIZE_W-1:0] MAX_SIZE_RESET = 13'd4096;

  typedef struct packed {
    logic [POINT_W-1:0] point_x;
    logic [POINT_W-1:0] point_y;
    logic               last_point;
  } in_t;

  typedef struct packed {
    logic [OUT_W-1:0] centroid_x;
    logic [OUT_W-1:0] centroid_y;
    logic             accepted;
    logic             too_long;
  } out_t;

endpackage

@@ hw/rtl/ccsf_front.sv @@
module ccsf_front #(
  parameter int COORD_BITS         = 12,
  parameter int MAX_CONTOUR_POINTS = 65535,
  parameter type JOB_T             = logic
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_beat,
  input  ccsf_pkg::in_t in_data,
  output logic          push,
  output JOB_T          job
);
  import ccsf_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int CNT_W = $clog2(MAX_CONTOUR_POINTS + 1);
  localparam int SW    = CW + CNT_W;
  localparam int XW    = (CW > POINT_W) ? CW : POINT_W;

  logic [SW-1:0]    sum_col_r, sum_row_r, sum_col_upd, sum_row_upd;
  logic [CNT_W-1:0] cnt_r, cnt_upd;
  logic             sat_r, sat_upd;
  logic [CW-1:0]    min_col_r, min_row_r, max_col_r, max_row_r;
  logic [CW-1:0]    min_col_upd, min_row_upd, max_col_upd, max_row_upd;
  logic [CW-1:0]    x_c, y_c;
  logic             can_add;

  assign x_c = CW'(XW'(in_data.point_x));
  assign y_c = CW'(XW'(in_data.point_y));

  // Once the count limit is reached, points only widen the box.
  assign can_add = cnt_r < CNT_W'(MAX_CONTOUR_POINTS);

  always_comb begin
    sum_col_upd = can_add ? sum_col_r + SW'(x_c) : sum_col_r;
    sum_row_upd = can_add ? sum_row_r + SW'(y_c) : sum_row_r;
    cnt_upd     = can_add ? cnt_r + CNT_W'(1) : cnt_r;
    sat_upd     = sat_r | ~can_add;
    min_col_upd = (x_c < min_col_r) ? x_c : min_col_r;
    min_row_upd = (y_c < min_row_r) ? y_c : min_row_r;
    max_col_upd = (x_c > max_col_r) ? x_c : max_col_r;
    max_row_upd = (y_c > max_row_r) ? y_c : max_row_r;
  end

  always_comb begin
    job.sum_col = sum_col_upd;
    job.sum_row = sum_row_upd;
    job.count   = cnt_upd;
    job.sat     = sat_upd;
    job.min_col = min_col_upd;
    job.min_row = min_row_upd;
    job.max_col = max_col_upd;
    job.max_row = max_row_upd;
  end

  assign push = in_beat & in_data.last_point;

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      sum_col_r <= '0;
      sum_row_r <= '0;
      cnt_r     <= '0;
      sat_r     <= 1'b0;
      min_col_r <= '1;
      min_row_r <= '1;
      max_col_r <= '0;
      max_row_r <= '0;
    end else if (in_beat) begin
      sum_col_r <= sum_col_upd;
      sum_row_r <= sum_row_upd;
      cnt_r     <= cnt_upd;
      sat_r     <= sat_upd;
      min_col_r <= min_col_upd;
      min_row_r <= min_row_upd;
      max_col_r <= max_col_upd;
      max_row_r <= max_row_upd;
    end
  end

endmodule

@@ hw/rtl/ccsf_queue.sv @@
module ccsf_queue #(
  parameter type T = logic
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     push_data,
  input  logic pop,
  output T     head,
  output logic empty,
  output logic full
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);

  T                mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] fill_r;

  assign empty = (fill_r == CNTW'(0));
  assign full  = (fill_r == CNTW'(DEPTH));
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + CNTW'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - CNTW'(1);
      end
    end
  end

endmodule

@@ hw/rtl/ccsf_back.sv @@
module ccsf_back #(
  parameter int COORD_BITS         = 12,
  parameter int MAX_CONTOUR_POINTS = 65535,
  parameter int FRAC_BITS          = 4,
  parameter type JOB_T             = logic
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ccsf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ccsf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  JOB_T                                job,
  input  logic                                job_empty,
  output logic                                job_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ccsf_pkg::out_t                      out_data
);
  import ccsf_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int CNT_W = $clog2(MAX_CONTOUR_POINTS + 1);
  localparam int SW    = CW + CNT_W;
  localparam int DW    = SW + FRAC_BITS;
  localparam int STW   = $clog2(DW + 1);
  localparam int BW    = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
  localparam int QW    = (DW > OUT_W) ? DW : OUT_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic              filter_en_r;
  logic [SIZE_W-1:0] min_size_r, max_size_r;

  logic [DW-1:0]    dvx_r, dvy_r, dvx_nxt, dvy_nxt;
  logic [CNT_W-1:0] remx_r, remy_r, remx_nxt, remy_nxt;
  logic [CNT_W-1:0] div_r;
  logic [STW-1:0]   step_r;
  logic             acc_r, sat_r, zero_r;

  logic [CNT_W:0]   shx, shy;
  logic             gex, gey;
  logic [BW-1:0]    w_col, w_row;
  logic             acc_calc;
  logic [QW-1:0]    qx, qy;
  logic [OUT_W-1:0] cx, cy;
  logic             out_load;
  logic             out_valid_r;
  out_t             out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_en_r <= 1'b0;
      min_size_r  <= MIN_SIZE_RESET;
      max_size_r  <= MAX_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FILTER_ENABLE: filter_en_r <= cfg_data[0];
        REG_MIN_SIZE:      min_size_r  <= cfg_data;
        REG_MAX_SIZE:      max_size_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Box width and height; an empty box counts as size zero.
  always_comb begin
    w_col = (job.max_col >= job.min_col) ?
            BW'(job.max_col) - BW'(job.min_col) + BW'(1) : '0;
    w_row = (job.max_row >= job.min_row) ?
            BW'(job.max_row) - BW'(job.min_row) + BW'(1) : '0;
    acc_calc = !filter_en_r ||
               (w_col >= BW'(min_size_r) && w_col <= BW'(max_size_r) &&
                w_row >= BW'(min_size_r) && w_row <= BW'(max_size_r));
  end

  // One restoring division step per cycle for each axis. The dividend
  // shifts out at the top while quotient bits fill in from the bottom.
  always_comb begin
    shx = {remx_r, dvx_r[DW-1]};
    shy = {remy_r, dvy_r[DW-1]};
    gex = shx >= {1'b0, div_r};
    gey = shy >= {1'b0, div_r};
    remx_nxt = gex ? CNT_W'(shx - {1'b0, div_r}) : CNT_W'(shx);
    remy_nxt = gey ? CNT_W'(shy - {1'b0, div_r}) : CNT_W'(shy);
    dvx_nxt  = {dvx_r[DW-2:0], gex};
    dvy_nxt  = {dvy_r[DW-2:0], gey};
  end

  always_comb begin
    qx = QW'(dvx_r);
    qy = QW'(dvy_r);
    cx = (qx > QW'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : OUT_W'(qx);
    cy = (qy > QW'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : OUT_W'(qy);
    if (zero_r) begin
      cx = '0;
      cy = '0;
    end
  end

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign job_pop  = (state_r == S_IDLE) && !job_empty;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (!job_empty) state_nxt = S_DIV;
      S_DIV:  if (step_r == STW'(1)) state_nxt = S_OUT;
      S_OUT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      dvx_r  <= {job.sum_col, {FRAC_BITS{1'b0}}};
      dvy_r  <= {job.sum_row, {FRAC_BITS{1'b0}}};
      remx_r <= '0;
      remy_r <= '0;
      div_r  <= job.count;
      step_r <= STW'(DW);
      acc_r  <= acc_calc;
      sat_r  <= job.sat;
      zero_r <= (job.count == '0);
    end else if (state_r == S_DIV) begin
      dvx_r  <= dvx_nxt;
      dvy_r  <= dvy_nxt;
      remx_r <= remx_nxt;
      remy_r <= remy_nxt;
      step_r <= step_r - STW'(1);
    end
    if (out_load) begin
      out_data_r.centroid_x <= cx;
      out_data_r.centroid_y <= cy;
      out_data_r.accepted   <= acc_r;
      out_data_r.too_long   <= sat_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hw/rtl/contour_centroid_size_filter.sv @@
// Contour centroid with bounding-box size filter.
// The input channel carries one contour point per beat, with last_point set
// on the contour's final point. Points are taken one per cycle for as long
// as the two-entry contour queue has room; ordinary points need no other
// work, so a contour streams in at one point per cycle.
// On the last point the sums, count and box go into the queue and the
// accumulators clear for the next contour in the same cycle. The back end
// runs both centroid divisions side by side, one quotient bit per cycle.
// After the last point the job passes through the queue, the division
// steps and the output register. The bit-serial divider sets the sustained
// throughput: the back end takes no new contour until the last result is
// loaded, so short contours back up the queue and then hold in_ready low.
// The result sits in an output register: while the receiver stalls it
// holds, the divider finishes the next contour and waits, and the front
// keeps taking points until the queue fills.
// Configuration writes take effect at once and belong to idle periods.
// Reset clears the accumulators, queue and output valid, and returns the
// registers to filter off, min_size 1, max_size 4096.
module contour_centroid_size_filter #(
  parameter int COORD_BITS         = 12,
  parameter int MAX_CONTOUR_POINTS = 65535,
  parameter int FRAC_BITS          = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ccsf_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ccsf_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [ccsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ccsf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ccsf_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int CNT_W = $clog2(MAX_CONTOUR_POINTS + 1);
  localparam int SW    = CW + CNT_W;

  typedef struct packed {
    logic [SW-1:0]    sum_col;
    logic [SW-1:0]    sum_row;
    logic [CNT_W-1:0] count;
    logic             sat;
    logic [CW-1:0]    min_col;
    logic [CW-1:0]    min_row;
    logic [CW-1:0]    max_col;
    logic [CW-1:0]    max_row;
  } job_t;

  job_t job_in, job_head;
  logic push, pop, q_empty, q_full, in_beat;

  assign in_ready = !q_full;
  assign in_beat  = in_valid && in_ready;

  ccsf_front #(
    .COORD_BITS        (COORD_BITS),
    .MAX_CONTOUR_POINTS(MAX_CONTOUR_POINTS),
    .JOB_T             (job_t)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_beat(in_beat),
    .in_data(in_data),
    .push   (push),
    .job    (job_in)
  );

  ccsf_queue #(
    .T(job_t)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(job_in),
    .pop      (pop),
    .head     (job_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  ccsf_back #(
    .COORD_BITS        (COORD_BITS),
    .MAX_CONTOUR_POINTS(MAX_CONTOUR_POINTS),
    .FRAC_BITS         (FRAC_BITS),
    .JOB_T             (job_t)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .job      (job_head),
    .job_empty(q_empty),
    .job_pop  (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
